>>> rtl/lscn_pkg.sv
// Shared types and constants for the line sensor calibrate/normalize block.
// No dependencies; used by every other file in rtl/ except lscn_ram.
package lscn_pkg;

    // Input mode codes
    typedef enum logic [1:0] {
        MODE_MEASURE     = 2'd0,
        MODE_BLACK       = 2'd1,
        MODE_WHITE       = 2'd2,
        MODE_RAISE_WHITE = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_AVG,
        S_UPDATE,
        S_DIV_PCT,
        S_EMIT
    } state_t;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam int PERCENT_SCALE = 100;
    localparam logic [7:0] DEFAULT_SAMPLES = 8'd20;

endpackage

>>> rtl/line_sensor_calibrate_normalize.sv
// Top level of the line sensor calibrate/normalize block.
// Depends on lscn_pkg, lscn_ram and lscn_div.
//
//  Channel  Signals                                     Direction  Transaction moves
//  -------  ------------------------------------------  ---------  ---------------------------
//  in       in_valid/in_ready, mode, channel, sample    sink       one converter sample
//  out      out_valid/out_ready, out_channel, average,  source     one completed average
//           percent, zero_span
//  cfg      cfg_valid/cfg_ready, cfg_data               sink       samples_per_average write
//
// Sequence: a sample that does not complete an average is absorbed and in_ready
// stays high. A completing sample takes one pass of the shared bit-serial divider
// in capture modes, and a second pass for the percentage in measure mode when the
// span is nonzero.
// Reset: asynchronous, active low; clears the accumulator, count, channel valid
// bits (so every reference reads as zero) and the register back to 20. No sweep.
// Stalls: in_ready is low while a completed average is in progress; the output
// register holds one result, so a new sample is taken while it waits.
module line_sensor_calibrate_normalize #(
    parameter int CHANNELS    = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // sample input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    mode,
    input  logic [2:0]                    channel,
    input  logic [SAMPLE_BITS-1:0]        sample,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    out_channel,
    output logic [SAMPLE_BITS-1:0]        average,
    output logic signed [SAMPLE_BITS+7:0] percent,
    output logic                          zero_span,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + 8;        // accumulator and dividend width
    localparam int PCT_W = SAMPLE_BITS + 8;        // signed percentage width
    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ENT_W = 3 * SAMPLE_BITS;        // {latest, black, white}

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    lscn_pkg::state_t state_reg, state_next;

    logic [7:0]             spa_reg;               // samples_per_average
    logic [SUM_W-1:0]       sum_reg;
    logic [7:0]             cnt_reg;
    logic [CHANNELS-1:0]    vld_reg;               // channel entry written since reset
    logic                   rd_vld_reg;            // valid bit of the entry being read

    logic [1:0]             mode_reg;
    logic [2:0]             ch_reg;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [PCT_W-1:0]       res_pct_reg;
    logic                   res_zs_reg;
    logic                   pct_neg_reg;

    logic                   out_valid_reg;
    logic [2:0]             out_ch_reg;
    logic [SAMPLE_BITS-1:0] out_avg_reg;
    logic [PCT_W-1:0]       out_pct_reg;
    logic                   out_zs_reg;

    // ---------------------------------------------------------------
    // Combinational signals
    // ---------------------------------------------------------------
    logic                   in_fire;
    logic                   ch_ok;
    logic [7:0]             n_eff;
    logic [SUM_W-1:0]       sum_next;
    logic [7:0]             cnt_next;
    logic                   run_done;
    logic                   out_free;
    logic [AW-1:0]          in_addr;
    logic [AW-1:0]          ch_addr;

    logic                   ram_re;
    logic                   ram_we;
    logic                   div_start;
    logic                   emit;
    logic [ENT_W-1:0]       ram_rdata;
    logic [ENT_W-1:0]       entry;
    logic [ENT_W-1:0]       entry_new;
    logic [SAMPLE_BITS-1:0] old_latest, old_black, old_white;

    logic [SUM_W-1:0]       div_num;
    logic [SAMPLE_BITS-1:0] div_den;
    logic [SUM_W-1:0]       div_q;
    lscn_pkg::div_stat_t    div_stat;

    logic [SAMPLE_BITS-1:0] avg_sat;
    logic [SAMPLE_BITS:0]   num_diff, den_diff;
    logic [SAMPLE_BITS:0]   num_abs, den_abs;
    logic [SUM_W-1:0]       pct_signed;
    logic                   span_zero;
    logic                   measure;

    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign ch_ok     = ({29'd0, channel} < 32'(CHANNELS));
    assign n_eff     = (spa_reg == 8'd0) ? 8'd1 : spa_reg;
    assign sum_next  = sum_reg + SUM_W'(sample);
    assign cnt_next  = cnt_reg + 8'd1;
    assign run_done  = ch_ok && (cnt_next >= n_eff);
    assign out_free  = !out_valid_reg || out_ready;
    assign in_addr   = AW'(channel);
    assign ch_addr   = AW'(ch_reg);
    assign measure   = (lscn_pkg::mode_t'(mode_reg) == lscn_pkg::MODE_MEASURE);

    // Entry unwritten since reset reads as all zero
    assign entry = rd_vld_reg ? ram_rdata : '0;
    assign old_latest = entry[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
    assign old_black  = entry[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign old_white  = entry[SAMPLE_BITS-1:0];

    // Quotient of sum/n saturates at the sample range (count lowered mid-run)
    assign avg_sat = (|div_q[SUM_W-1:SAMPLE_BITS]) ? '1 : div_q[SAMPLE_BITS-1:0];

    // Percentage operands as magnitudes; sign applied after division
    assign num_diff  = {1'b0, avg_reg} - {1'b0, old_black};
    assign den_diff  = {1'b0, old_white} - {1'b0, old_black};
    assign num_abs   = num_diff[SAMPLE_BITS] ? (~num_diff + 1'b1) : num_diff;
    assign den_abs   = den_diff[SAMPLE_BITS] ? (~den_diff + 1'b1) : den_diff;
    assign span_zero = (old_white == old_black);
    assign pct_signed = pct_neg_reg ? (~div_q + 1'b1) : div_q;

    // New entry contents by mode
    always_comb
    begin
        entry_new = entry;
        unique case (lscn_pkg::mode_t'(mode_reg))
            lscn_pkg::MODE_MEASURE:
            begin
                entry_new[3*SAMPLE_BITS-1:2*SAMPLE_BITS] = avg_reg;
            end
            lscn_pkg::MODE_BLACK:
            begin
                entry_new[3*SAMPLE_BITS-1:2*SAMPLE_BITS] = avg_reg;
                entry_new[2*SAMPLE_BITS-1:SAMPLE_BITS]   = avg_reg;
            end
            lscn_pkg::MODE_WHITE:
            begin
                entry_new[3*SAMPLE_BITS-1:2*SAMPLE_BITS] = avg_reg;
                entry_new[SAMPLE_BITS-1:0]               = avg_reg;
            end
            lscn_pkg::MODE_RAISE_WHITE:
            begin
                entry_new[3*SAMPLE_BITS-1:2*SAMPLE_BITS] = old_latest;
                if (avg_reg > old_white)
                begin
                    entry_new[SAMPLE_BITS-1:0] = avg_reg;
                end
            end
            default:
            begin
                entry_new = entry;
            end
        endcase
    end

    // Divider operand select: average pass at accept, percentage pass in UPDATE
    always_comb
    begin
        if (state_reg == lscn_pkg::S_UPDATE)
        begin
            div_num = SUM_W'(num_abs[SAMPLE_BITS-1:0]) * SUM_W'(lscn_pkg::PERCENT_SCALE);
            div_den = den_abs[SAMPLE_BITS-1:0];
        end
        else
        begin
            div_num = sum_next;
            div_den = SAMPLE_BITS'(n_eff);
        end
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lscn_pkg::S_IDLE:
            begin
                if (in_fire && run_done)
                begin
                    state_next = lscn_pkg::S_DIV_AVG;
                end
            end
            lscn_pkg::S_DIV_AVG:
            begin
                if (div_stat.done)
                begin
                    state_next = lscn_pkg::S_UPDATE;
                end
            end
            lscn_pkg::S_UPDATE:
            begin
                if (measure && !span_zero)
                begin
                    state_next = lscn_pkg::S_DIV_PCT;
                end
                else
                begin
                    state_next = lscn_pkg::S_EMIT;
                end
            end
            lscn_pkg::S_DIV_PCT:
            begin
                if (div_stat.done)
                begin
                    state_next = lscn_pkg::S_EMIT;
                end
            end
            lscn_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = lscn_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lscn_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: outputs
    // ---------------------------------------------------------------
    always_comb
    begin
        in_ready  = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            lscn_pkg::S_IDLE:
            begin
                in_ready  = 1'b1;
                ram_re    = in_fire && run_done;
                div_start = in_fire && run_done;
            end
            lscn_pkg::S_DIV_AVG:
            begin
            end
            lscn_pkg::S_UPDATE:
            begin
                ram_we    = 1'b1;
                div_start = measure && !span_zero;
            end
            lscn_pkg::S_DIV_PCT:
            begin
            end
            lscn_pkg::S_EMIT:
            begin
                emit = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lscn_pkg::S_IDLE;
            spa_reg       <= lscn_pkg::DEFAULT_SAMPLES;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            vld_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                spa_reg <= cfg_data;
            end
            // out-of-range channels leave the run untouched
            if (in_fire && ch_ok)
            begin
                if (run_done)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                end
            end
            if (ram_re)
            begin
                rd_vld_reg <= vld_reg[in_addr];
            end
            if (ram_we)
            begin
                vld_reg[ch_addr] <= 1'b1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Payload registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            mode_reg <= mode;
            ch_reg   <= channel;
        end
        if (state_reg == lscn_pkg::S_DIV_AVG && div_stat.done)
        begin
            avg_reg <= avg_sat;
        end
        if (state_reg == lscn_pkg::S_UPDATE)
        begin
            res_pct_reg <= '0;
            res_zs_reg  <= measure && span_zero;
            pct_neg_reg <= num_diff[SAMPLE_BITS] ^ den_diff[SAMPLE_BITS];
        end
        if (state_reg == lscn_pkg::S_DIV_PCT && div_stat.done)
        begin
            res_pct_reg <= pct_signed;
        end
        if (emit)
        begin
            out_ch_reg  <= ch_reg;
            out_avg_reg <= avg_reg;
            out_pct_reg <= res_pct_reg;
            out_zs_reg  <= res_zs_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_ch_reg;
    assign average     = out_avg_reg;
    assign percent     = out_pct_reg;
    assign zero_span   = out_zs_reg;

    // ---------------------------------------------------------------
    // Per-channel store and shared divider
    // ---------------------------------------------------------------
    // Reads happen only in IDLE and writes only in UPDATE, so the sequencer
    // keeps read and write of one entry from overlapping.
    lscn_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ch_addr),
        .wdata (entry_new),
        .re    (ram_re),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    lscn_div #(
        .N_W (SUM_W),
        .D_W (SAMPLE_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == lscn_pkg::S_DIV_AVG ||
                           state_reg == lscn_pkg::S_DIV_PCT))
        else $error("divider finished outside a divide state");

    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != lscn_pkg::S_IDLE) |-> (sum_reg == '0 && cnt_reg == '0))
        else $error("accumulator not cleared while an average is in progress");

    a_complete_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && run_done) |=> (state_reg == lscn_pkg::S_DIV_AVG && div_stat.busy))
        else $error("completed run did not start the average division");

    a_zero_span_pct: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && zero_span) |-> (percent == '0))
        else $error("zero span result carries a nonzero percentage");

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider restarted while busy");

endmodule

>>> rtl/lscn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module lscn_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lscn_div.sv
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on lscn_pkg (div_stat_t).
module lscn_div #(
    parameter int N_W = 18,
    parameter int D_W = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [N_W-1:0]      num,
    input  logic [D_W-1:0]      den,
    output lscn_pkg::div_stat_t stat,
    output logic [N_W-1:0]      quotient
);

    localparam int CW = (N_W > 1) ? $clog2(N_W) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [D_W-1:0] rem_reg;
    logic [N_W-1:0] quo_reg;
    logic [D_W-1:0] den_reg;

    logic [D_W:0]   trial;
    logic           ge;
    logic [D_W:0]   diff;
    logic [D_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[N_W-1]};
        diff     = trial - {1'b0, den_reg};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? diff[D_W-1:0] : trial[D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(N_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[N_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

>>> tb/lscn_checker.sv
// Scoreboard for line_sensor_calibrate_normalize: watches the sample, result and
// configuration channels, predicts every completed average and compares it.
// Depends on lscn_pkg.
module lscn_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [1:0]         mode,
    input  logic [2:0]         channel,
    input  logic [9:0]         sample,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [2:0]         out_channel,
    input  logic [9:0]         average,
    input  logic signed [17:0] percent,
    input  logic               zero_span,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [7:0]         cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 averages_checked
);

    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [2:0]         ch;
        logic [9:0]         avg;
        logic signed [17:0] pct;
        logic               zs;
    } avg_result_t;

    avg_result_t expected_averages[$];
    avg_result_t want;

    logic [7:0]  count_setting;
    logic [17:0] run_sum;
    logic [7:0]  run_count;
    logic [9:0]  latest_avg [8];
    logic [9:0]  black_ref [8];
    logic [9:0]  white_ref [8];

    task automatic accumulate_sample(input lscn_pkg::mode_t m, input logic [2:0] ch,
                                     input logic [9:0] smp);
        int          n;
        int          quotient;
        int          span;
        avg_result_t r;
        n = (count_setting == 8'd0) ? 1 : int'(count_setting);
        run_sum   = run_sum + 18'(smp);
        run_count = run_count + 8'd1;
        if (int'(run_count) >= n) begin
            // a lowered count can leave a sum worth more than n samples
            quotient = int'(run_sum) / n;
            if (quotient > 1023)
                quotient = 1023;
            run_sum   = '0;
            run_count = '0;
            r.ch  = ch;
            r.avg = 10'(quotient);
            r.pct = '0;
            r.zs  = 1'b0;
            case (m)
                lscn_pkg::MODE_RAISE_WHITE:
                begin
                    if (r.avg > white_ref[ch])
                        white_ref[ch] = r.avg;
                end
                lscn_pkg::MODE_BLACK:
                begin
                    latest_avg[ch] = r.avg;
                    black_ref[ch]  = r.avg;
                end
                lscn_pkg::MODE_WHITE:
                begin
                    latest_avg[ch] = r.avg;
                    white_ref[ch]  = r.avg;
                end
                default:
                begin
                    latest_avg[ch] = r.avg;
                    span = int'(white_ref[ch]) - int'(black_ref[ch]);
                    if (span == 0)
                        r.zs = 1'b1;
                    else
                        r.pct = 18'((quotient - int'(black_ref[ch])) *
                                    lscn_pkg::PERCENT_SCALE / span);
                end
            endcase
            expected_averages.push_back(r);
        end
    endtask

    task automatic note_mismatch(input string field, input int exp_v, input int act_v);
        fail_count++;
        if (fail_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_averages.delete();
            count_setting    = lscn_pkg::DEFAULT_SAMPLES;
            run_sum          = '0;
            run_count        = '0;
            fail_count       = 0;
            pending          = 0;
            averages_checked = 0;
            for (int k = 0; k < 8; k++)
            begin
                latest_avg[k] = '0;
                black_ref[k]  = '0;
                white_ref[k]  = '0;
            end
        end
        else
        begin
            // results first: one accepted this edge cannot stem from this edge's sample
            if (out_valid && out_ready)
            begin
                averages_checked++;
                if (expected_averages.size() == 0)
                    note_mismatch("unexpected result, out_channel", -1, int'(out_channel));
                else
                begin
                    want = expected_averages.pop_front();
                    if (want.ch !== out_channel)
                        note_mismatch("out_channel", int'(want.ch), int'(out_channel));
                    if (want.avg !== average)
                        note_mismatch("average", int'(want.avg), int'(average));
                    if (want.pct !== percent)
                        note_mismatch("percent", int'($signed(want.pct)), int'(percent));
                    if (want.zs !== zero_span)
                        note_mismatch("zero_span", int'(want.zs), int'(zero_span));
                end
            end
            // a sample taken at the same edge as a write still sees the old count
            if (in_valid && in_ready)
                accumulate_sample(lscn_pkg::mode_t'(mode), channel, sample);
            if (cfg_valid && cfg_ready)
                count_setting = cfg_data;
            pending = expected_averages.size();
        end
    end

endmodule

>>> tb/tb_line_sensor_calibrate_normalize.sv
// Top of the line_sensor_calibrate_normalize testbench: clock, reset, sample and
// config stimulus, result sink with back-pressure, verdict.
// Depends on lscn_pkg, the block itself and lscn_checker.
module tb_line_sensor_calibrate_normalize;

    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 115;
    localparam int HOLD_PHASE   = 7;     // sink holds off long here
    localparam int PAUSE_PHASE  = 4;     // sender drains mid-phase here
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 60;    // outlasts one measure pass
    localparam int DRAIN_LIMIT  = 20000;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [1:0]         mode      = lscn_pkg::MODE_MEASURE;
    logic [2:0]         channel   = '0;
    logic [9:0]         sample    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         out_channel;
    logic [9:0]         average;
    logic signed [17:0] percent;
    logic               zero_span;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [7:0]         cfg_data  = '0;

    int fail_count;
    int pending;
    int averages_checked;

    // shared between stimulus and sink
    logic no_idle  = 1'b0;
    logic hold_req = 1'b0;

    // stimulus bookkeeping
    int              samples_sent   = 0;
    int              settings_used  = 0;
    logic            drain_timeout  = 1'b0;
    lscn_pkg::mode_t run_mode;
    int              run_ch;
    int              run_level;
    int              run_len;
    int              run_left;

    // negative entry: pick a small random count
    int phase_setting [PHASES] = '{1, 255, 2, 0, -1, 3, 20, 1, -1, 2};

    line_sensor_calibrate_normalize #(
        .CHANNELS    (8),
        .SAMPLE_BITS (10)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .channel     (channel),
        .sample      (sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_channel (out_channel),
        .average     (average),
        .percent     (percent),
        .zero_span   (zero_span),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    lscn_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .channel          (channel),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_channel      (out_channel),
        .average          (average),
        .percent          (percent),
        .zero_span        (zero_span),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .fail_count       (fail_count),
        .pending          (pending),
        .averages_checked (averages_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop well past the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("FAIL line_sensor_calibrate_normalize");
        $finish;
    end

    // Result sink: random gap per transaction, one long hold-off on request.
    // Drives at the falling edge, sees the handshake at the rising edge.
    initial
    begin : result_sink
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                // long stall: block output reg fills, in_ready drops
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 11);
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // One sample transaction. Returns at the falling edge after acceptance with
    // in_valid still high; the caller either offers the next one or lowers it.
    task automatic send_sample(input lscn_pkg::mode_t m, input int ch, input int smp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        channel  <= 3'(ch);
        sample   <= 10'(smp);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
    endtask

    // Always advances the clock before returning, so a following send never lands
    // in the same step as idle_input.
    task automatic wait_drained();
        int waited;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (pending != 0 && waited < DRAIN_LIMIT);
        if (pending != 0)
            drain_timeout = 1'b1;
    endtask

    // Count register writes only with the pipeline empty; a partial run in
    // the accumulator is fine (that is how a lowered count gets exercised).
    task automatic change_setting(input logic [7:0] value);
        idle_input();
        wait_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Mostly whole runs of one mode/channel around one level (black, white,
    // measure sequences), with about one sample in ten as noise.
    task automatic random_item();
        int              pick;
        int              smp;
        lscn_pkg::mode_t m;
        int              ch;
        if (run_left == 0)
        begin
            pick = $urandom_range(0, 9);
            run_mode = (pick < 4) ? lscn_pkg::MODE_MEASURE :
                       (pick < 6) ? lscn_pkg::MODE_BLACK   :
                       (pick < 8) ? lscn_pkg::MODE_WHITE   : lscn_pkg::MODE_RAISE_WHITE;
            run_ch = $urandom_range(0, 7);
            pick = $urandom_range(0, 9);
            run_level = (pick == 0) ? 0 : (pick == 1) ? 1023 : $urandom_range(0, 1023);
            run_left = run_len;
        end
        run_left--;
        if ($urandom_range(0, 9) == 0)
        begin
            m   = lscn_pkg::mode_t'($urandom_range(0, 3));
            ch  = $urandom_range(0, 7);
            smp = $urandom_range(0, 1023);
        end
        else
        begin
            m   = run_mode;
            ch  = run_ch;
            smp = run_level + $urandom_range(0, 40) - 20;
            if (smp < 0)
                smp = 0;
            if (smp > 1023)
                smp = 1023;
        end
        send_sample(m, ch, smp);
    endtask

    initial
    begin : stimulus
        int setting;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed: one sample per average ----
        change_setting(8'd1);
        send_sample(lscn_pkg::MODE_MEASURE, 0, 0);          // refs still zero: zero span
        send_sample(lscn_pkg::MODE_BLACK, 2, 100);
        send_sample(lscn_pkg::MODE_WHITE, 2, 900);
        send_sample(lscn_pkg::MODE_MEASURE, 2, 500);        // 50
        send_sample(lscn_pkg::MODE_MEASURE, 2, 0);          // negative, truncated toward zero
        send_sample(lscn_pkg::MODE_MEASURE, 2, 1023);       // above white
        send_sample(lscn_pkg::MODE_BLACK, 3, 1023);         // inverted references
        send_sample(lscn_pkg::MODE_WHITE, 3, 0);
        send_sample(lscn_pkg::MODE_MEASURE, 3, 512);
        send_sample(lscn_pkg::MODE_BLACK, 5, 1023);         // span of -1: largest percent
        send_sample(lscn_pkg::MODE_WHITE, 5, 1022);
        send_sample(lscn_pkg::MODE_MEASURE, 5, 0);
        send_sample(lscn_pkg::MODE_WHITE, 6, 1);            // span of +1
        send_sample(lscn_pkg::MODE_MEASURE, 6, 1023);
        send_sample(lscn_pkg::MODE_WHITE, 4, 500);
        send_sample(lscn_pkg::MODE_RAISE_WHITE, 4, 400);    // smaller: white kept
        send_sample(lscn_pkg::MODE_RAISE_WHITE, 4, 700);    // larger: white raised
        send_sample(lscn_pkg::MODE_MEASURE, 4, 350);
        send_sample(lscn_pkg::MODE_RAISE_WHITE, 7, 1023);
        send_sample(lscn_pkg::MODE_MEASURE, 7, 1023);

        // zero count behaves as one
        change_setting(8'd0);
        send_sample(lscn_pkg::MODE_MEASURE, 1, 1023);

        // mixed run: completes on the last sample's channel and mode
        change_setting(8'd3);
        send_sample(lscn_pkg::MODE_WHITE, 0, 1023);
        send_sample(lscn_pkg::MODE_BLACK, 1, 0);
        send_sample(lscn_pkg::MODE_MEASURE, 6, 2);

        // count lowered mid-run: saturated average on the next sample
        change_setting(8'd255);
        send_sample(lscn_pkg::MODE_MEASURE, 3, 1023);
        send_sample(lscn_pkg::MODE_BLACK, 5, 1023);
        send_sample(lscn_pkg::MODE_WHITE, 6, 1023);
        change_setting(8'd1);
        send_sample(lscn_pkg::MODE_MEASURE, 0, 1023);

        // ---- random phases ----
        for (int p = 0; p < PHASES; p++)
        begin
            setting = (phase_setting[p] < 0) ? $urandom_range(1, 8) : phase_setting[p];
            change_setting(8'(setting));
            run_len  = (setting == 0) ? 1 : setting;
            run_left = 0;
            no_idle  = (p % 3 == 2);
            if (p == HOLD_PHASE)
                hold_req = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (p == PAUSE_PHASE && k == PHASE_ITEMS / 2)
                begin
                    idle_input();
                    wait_drained();
                end
                random_item();
            end
        end

        idle_input();
        wait_drained();
        repeat (SETTLE) @(negedge clk);

        $display("Run covered %0d samples and %0d averages over %0d count settings,",
                 samples_sent, averages_checked, settings_used);
        $display("incl. zero and full counts, a lowered count mid-run and output back-pressure.");
        if (fail_count == 0 && !drain_timeout)
            $display("PASS line_sensor_calibrate_normalize");
        else
            $display("FAIL line_sensor_calibrate_normalize");
        $finish;
    end

endmodule

>>> sim.f
rtl/lscn_pkg.sv
rtl/lscn_ram.sv
rtl/lscn_div.sv
rtl/line_sensor_calibrate_normalize.sv
tb/lscn_checker.sv
tb/tb_line_sensor_calibrate_normalize.sv
